// File: rtl/lpht_pkg.sv
// Shared types, codes and constants of the linear-probe hash table.
package lpht_pkg;

   // Field widths
   localparam int LPHT_CMD_W      = 2;
   localparam int LPHT_KEY_W      = 31;
   localparam int LPHT_VALUE_W    = 32;
   localparam int LPHT_STATUS_W   = 2;
   localparam int LPHT_SLOT_OUT_W = 10;
   localparam int LPHT_MARK_W     = 2;

   // Stream data widths, padded to whole bytes
   localparam int LPHT_REQ_DATA_W = 64;
   localparam int LPHT_RSP_DATA_W = 48;
   localparam int LPHT_RSP_PAD_W  = LPHT_RSP_DATA_W - LPHT_SLOT_OUT_W - LPHT_VALUE_W;

   localparam int LPHT_DEFAULT_SLOTS = 1024;

   // Home slot hash: multiplier term is (HASH_MULT - key mod HASH_MULT)
   localparam int LPHT_HASH_MULT    = 7;
   localparam int LPHT_HASH_DIGIT_W = 4;
   localparam int LPHT_HASH_DIGITS  = (LPHT_KEY_W + LPHT_HASH_DIGIT_W - 1) / LPHT_HASH_DIGIT_W;
   localparam int LPHT_HASH_PAD_W   = LPHT_HASH_DIGITS * LPHT_HASH_DIGIT_W;

   // Slot marks
   localparam logic [LPHT_MARK_W-1:0] MARK_EMPTY   = 2'd0;
   localparam logic [LPHT_MARK_W-1:0] MARK_USED    = 2'd1;
   localparam logic [LPHT_MARK_W-1:0] MARK_DELETED = 2'd2;

   // Result status codes
   localparam logic [LPHT_STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [LPHT_STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [LPHT_STATUS_W-1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [LPHT_CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CLEAR  = 2'd3
   } lpht_cmd_type;

   typedef enum logic [2:0] {
      LPHT_IDLE,
      LPHT_CLEAR,
      LPHT_HASH,
      LPHT_PROBE,
      LPHT_REPLY
   } lpht_state_type;

   typedef struct packed {
      logic [LPHT_MARK_W-1:0]  mark;
      logic [LPHT_KEY_W-1:0]   key;
      logic [LPHT_VALUE_W-1:0] value;
   } lpht_entry_type;

   localparam int LPHT_ENTRY_W = $bits(lpht_entry_type);

endpackage

// File: rtl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lpht_hash.sv
// Home slot unit: shared digit-serial remainder datapath, then scale and reduce.
module lpht_hash import lpht_pkg::*; #(
   parameter int TABLE_SLOTS = LPHT_DEFAULT_SLOTS,
   localparam int SLOT_W     = $clog2(TABLE_SLOTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [LPHT_KEY_W-1:0] key,
   output logic                  done,
   output logic [SLOT_W-1:0]     home_slot
);

   localparam int PROD_W = SLOT_W + 3;
   localparam int STEP_W = $clog2(LPHT_HASH_DIGITS + 2);
   localparam logic [SLOT_W:0]   MOD_S  = (SLOT_W + 1)'(TABLE_SLOTS);
   localparam logic [3:0]        MOD_7  = 4'(LPHT_HASH_MULT);
   localparam logic [PROD_W-1:0] RED_1  = PROD_W'(TABLE_SLOTS);
   localparam logic [PROD_W-1:0] RED_2  = PROD_W'(2 * TABLE_SLOTS);
   localparam logic [PROD_W-1:0] RED_4  = PROD_W'(4 * TABLE_SLOTS);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [LPHT_HASH_PAD_W-1:0] key_sr_ff, key_sr_in;
   logic [SLOT_W-1:0]          rem_s_ff, rem_s_in;
   logic [2:0]                 rem_7_ff, rem_7_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [SLOT_W-1:0]          home_ff, home_in;

   // one digit of both remainders per cycle
   logic [SLOT_W-1:0] dig_s;
   logic [2:0]        dig_7;

   always_comb begin
      logic [SLOT_W:0] ws;
      logic [3:0]      w7;
      dig_s = rem_s_ff;
      dig_7 = rem_7_ff;
      for (int i = 0; i < LPHT_HASH_DIGIT_W; i++) begin
         ws = {dig_s, key_sr_ff[LPHT_HASH_PAD_W-1-i]};
         if (ws >= MOD_S) begin
            ws = ws - MOD_S;
         end
         dig_s = ws[SLOT_W-1:0];
         w7 = {dig_7, key_sr_ff[LPHT_HASH_PAD_W-1-i]};
         if (w7 >= MOD_7) begin
            w7 = w7 - MOD_7;
         end
         dig_7 = w7[2:0];
      end
   end

   // product < 8 * slots: three conditional subtracts
   logic [PROD_W-1:0] red;

   always_comb begin
      red = prod_ff;
      if (red >= RED_4) begin
         red = red - RED_4;
      end
      if (red >= RED_2) begin
         red = red - RED_2;
      end
      if (red >= RED_1) begin
         red = red - RED_1;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      key_sr_in = key_sr_ff;
      rem_s_in  = rem_s_ff;
      rem_7_in  = rem_7_ff;
      prod_in   = prod_ff;
      home_in   = home_ff;
      if (start) begin
         busy_in   = 1'b1;
         step_in   = '0;
         key_sr_in = LPHT_HASH_PAD_W'(key);
         rem_s_in  = '0;
         rem_7_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff < STEP_W'(LPHT_HASH_DIGITS)) begin
            key_sr_in = key_sr_ff << LPHT_HASH_DIGIT_W;
            rem_s_in  = dig_s;
            rem_7_in  = dig_7;
         end else if (step_ff == STEP_W'(LPHT_HASH_DIGITS)) begin
            prod_in = PROD_W'(rem_s_ff) * PROD_W'(3'(LPHT_HASH_MULT) - rem_7_ff);
         end else begin
            home_in = red[SLOT_W-1:0];
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      key_sr_ff <= key_sr_in;
      rem_s_ff  <= rem_s_in;
      rem_7_ff  <= rem_7_in;
      prod_ff   <= prod_in;
      home_ff   <= home_in;
   end

   assign done      = done_ff;
   assign home_slot = home_ff;

endmodule

// File: rtl/linear_probe_hash_table.sv
// Linear-probe hash table top level: request sequencer, slot store and result register.
// Insert/search/delete: the hash unit runs 8 digit steps of 4 key bits, one multiply and
//   one reduce; then the probe loop reads one slot per cycle, 1 to TABLE_SLOTS slots in all.
// Clear: one slot written per cycle by the sweep.
// One request at a time; the next request is taken once the result reaches the output register.
// Reset: synchronous, active high; after reset a sweep empties the store,
//   and req_tready stays low until it is done.
module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int TABLE_SLOTS = LPHT_DEFAULT_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [LPHT_REQ_DATA_W-1:0] req_tdata,  // key[30:0], value[62:31], zero[63]
   input  logic [LPHT_CMD_W-1:0]      req_tuser,  // command[1:0]
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [LPHT_RSP_DATA_W-1:0] rsp_tdata,  // found_value[31:0], slot_index[41:32], zero
   output logic [LPHT_STATUS_W-1:0]   rsp_tuser   // status[1:0]
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

   // request fields
   lpht_cmd_type            req_cmd;
   logic [LPHT_KEY_W-1:0]   req_key;
   logic [LPHT_VALUE_W-1:0] req_value;

   assign req_cmd   = lpht_cmd_type'(req_tuser);
   assign req_key   = req_tdata[LPHT_KEY_W-1:0];
   assign req_value = req_tdata[LPHT_KEY_W +: LPHT_VALUE_W];

   // control state
   lpht_state_type state_ff, state_in;
   logic           init_ff, init_in;      // sweep after reset gives no result
   logic [SLOT_W-1:0] clr_ff, clr_in;     // clear sweep address
   logic [SLOT_W-1:0] probe_ff, probe_in; // slot under test
   logic [SLOT_W-1:0] count_ff, count_in; // slots probed so far
   logic           rsp_valid_ff, rsp_valid_in;

   // held request
   lpht_cmd_type            cmd_ff, cmd_in;
   logic [LPHT_KEY_W-1:0]   key_ff, key_in;
   logic [LPHT_VALUE_W-1:0] value_ff, value_in;

   // pending result and output register
   logic [LPHT_STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [LPHT_VALUE_W-1:0]    res_value_ff, res_value_in;
   logic [LPHT_SLOT_OUT_W-1:0] res_slot_ff, res_slot_in;
   logic [LPHT_STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [LPHT_VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [LPHT_SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // hash unit
   logic              hash_start;
   logic              hash_done;
   logic [SLOT_W-1:0] hash_home;

   lpht_hash #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (hash_start),
      .key       (req_key),
      .done      (hash_done),
      .home_slot (hash_home)
   );

   // slot store: mark, key and value of each slot in one word
   logic                    ram_wr_en;
   logic [SLOT_W-1:0]       ram_wr_addr;
   lpht_entry_type          ram_wr_entry;
   logic                    ram_rd_en;
   logic [SLOT_W-1:0]       ram_rd_addr;
   logic [LPHT_ENTRY_W-1:0] ram_rd_data;
   lpht_entry_type          rd_entry;

   lpht_ram #(
      .WIDTH (LPHT_ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = lpht_entry_type'(ram_rd_data);

   // probe evaluation on the slot read last cycle
   logic              slot_used;
   logic              slot_empty;
   logic              key_match;
   logic              last_probe;
   logic              clr_last;
   logic              out_free;
   logic [SLOT_W-1:0] next_probe;

   assign slot_used  = (rd_entry.mark == MARK_USED);
   assign slot_empty = (rd_entry.mark == MARK_EMPTY);
   assign key_match  = (rd_entry.key == key_ff);
   assign last_probe = (count_ff == LAST_SLOT);
   assign clr_last   = (clr_ff == LAST_SLOT);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign next_probe = (probe_ff == LAST_SLOT) ? '0 : probe_ff + 1'b1;

   logic probe_stop;

   always_comb begin
      probe_stop = 1'b0;
      case (cmd_ff)
         CMD_INSERT: begin
            probe_stop = !slot_used || last_probe;
         end
         CMD_SEARCH, CMD_DELETE: begin
            probe_stop = slot_empty || (slot_used && key_match) || last_probe;
         end
         default: begin
            probe_stop = 1'b1;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LPHT_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_cmd == CMD_CLEAR) ? LPHT_CLEAR : LPHT_HASH;
            end
         end
         LPHT_CLEAR: begin
            if (clr_last) begin
               state_in = init_ff ? LPHT_IDLE : LPHT_REPLY;
            end
         end
         LPHT_HASH: begin
            if (hash_done) begin
               state_in = LPHT_PROBE;
            end
         end
         LPHT_PROBE: begin
            if (probe_stop) begin
               state_in = LPHT_REPLY;
            end
         end
         LPHT_REPLY: begin
            if (out_free) begin
               state_in = LPHT_IDLE;
            end
         end
         default: begin
            state_in = LPHT_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_tready    = 1'b0;
      hash_start    = 1'b0;
      init_in       = init_ff;
      clr_in        = clr_ff;
      probe_in      = probe_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_slot_in   = res_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = probe_ff;
      ram_wr_entry  = rd_entry;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = next_probe;
      case (state_ff)
         LPHT_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in        = req_cmd;
               key_in        = req_key;
               value_in      = req_value;
               hash_start    = (req_cmd != CMD_CLEAR);
               clr_in        = '0;
               res_status_in = STATUS_OK;
               res_value_in  = '0;
               res_slot_in   = '0;
            end
         end
         LPHT_CLEAR: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = clr_ff;
            ram_wr_entry = '0;
            clr_in       = clr_last ? '0 : clr_ff + 1'b1;
            if (clr_last) begin
               init_in = 1'b0;
            end
         end
         LPHT_HASH: begin
            // first read goes to the home slot
            if (hash_done) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = hash_home;
               probe_in    = hash_home;
               count_in    = '0;
            end
         end
         LPHT_PROBE: begin
            // read the following slot ahead; used only if the walk goes on
            ram_rd_en = 1'b1;
            if (!probe_stop) begin
               probe_in = next_probe;
               count_in = count_ff + 1'b1;
            end else begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (!slot_used) begin
                        ram_wr_en          = 1'b1;
                        ram_wr_entry.mark  = MARK_USED;
                        ram_wr_entry.key   = key_ff;
                        ram_wr_entry.value = value_ff;
                        res_slot_in        = LPHT_SLOT_OUT_W'(probe_ff);
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  CMD_SEARCH: begin
                     if (slot_used && key_match) begin
                        res_value_in = rd_entry.value;
                        res_slot_in  = LPHT_SLOT_OUT_W'(probe_ff);
                     end else begin
                        res_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  CMD_DELETE: begin
                     if (slot_used && key_match) begin
                        ram_wr_en         = 1'b1;
                        ram_wr_entry.mark = MARK_DELETED;  // tombstone keeps chains intact
                        res_slot_in       = LPHT_SLOT_OUT_W'(probe_ff);
                     end else begin
                        res_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         LPHT_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_slot_in   = res_slot_ff;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LPHT_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      probe_ff      <= probe_in;
      count_ff      <= count_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {LPHT_RSP_PAD_W'(0), rsp_slot_ff, rsp_value_ff};

endmodule

// File: verif/lpht_checker.sv
// Result checker for the linear-probe hash table: shadow table, expected-result queue, compare.
`timescale 1ns / 100ps

module lpht_checker import lpht_pkg::*; #(
   parameter int TABLE_SLOTS = LPHT_DEFAULT_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [LPHT_REQ_DATA_W-1:0] req_tdata,
   input  logic [LPHT_CMD_W-1:0]      req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [LPHT_RSP_DATA_W-1:0] rsp_tdata,
   input  logic [LPHT_STATUS_W-1:0]   rsp_tuser,
   output int                         mismatch_count,
   output int                         pending_results
);

   typedef struct packed {
      logic [LPHT_STATUS_W-1:0]   status;
      logic [LPHT_VALUE_W-1:0]    found_value;
      logic [LPHT_SLOT_OUT_W-1:0] slot_index;
   } table_result_t;

   // shadow copy of the slot store
   logic [LPHT_MARK_W-1:0]  shadow_mark  [TABLE_SLOTS];
   logic [LPHT_KEY_W-1:0]   shadow_key   [TABLE_SLOTS];
   logic [LPHT_VALUE_W-1:0] shadow_value [TABLE_SLOTS];
   int unsigned             shadow_count;

   table_result_t awaited_results [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
   end

   function automatic int unsigned home_of(input logic [LPHT_KEY_W-1:0] key);
      int unsigned k;
      int unsigned a;
      int unsigned b;
      k = key;
      a = k % TABLE_SLOTS;
      b = LPHT_HASH_MULT - (k % LPHT_HASH_MULT);
      return (a * b) % TABLE_SLOTS;
   endfunction

   function automatic int unsigned step_slot(input int unsigned s);
      return (s + 1 >= TABLE_SLOTS) ? 0 : s + 1;
   endfunction

   // walk from home; stops at an empty slot, at the key or after a full lap
   function automatic bit locate_key(input logic [LPHT_KEY_W-1:0] key,
                                     output int unsigned where);
      int unsigned s;
      int unsigned n;
      bit done;
      bit hit;
      s = home_of(key);
      n = 0;
      done = 1'b0;
      hit = 1'b0;
      where = 0;
      while (!done && n < TABLE_SLOTS) begin
         if (shadow_mark[s] == MARK_EMPTY) begin
            done = 1'b1;
         end else if (shadow_mark[s] == MARK_USED && shadow_key[s] == key) begin
            done = 1'b1;
            hit = 1'b1;
            where = s;
         end else begin
            s = step_slot(s);
            n++;
         end
      end
      return hit;
   endfunction

   function automatic table_result_t apply_request(input lpht_cmd_type cmd,
                                                   input logic [LPHT_KEY_W-1:0] key,
                                                   input logic [LPHT_VALUE_W-1:0] value);
      table_result_t r;
      int unsigned s;
      int unsigned n;
      bit hit;
      r = '0;
      r.status = STATUS_OK;
      case (cmd)
         CMD_INSERT: begin
            s = home_of(key);
            n = 0;
            hit = 1'b0;
            while (!hit && n < TABLE_SLOTS) begin
               if (shadow_mark[s] != MARK_USED) begin
                  hit = 1'b1;
               end else begin
                  s = step_slot(s);
                  n++;
               end
            end
            if (hit) begin
               shadow_key[s]   = key;
               shadow_value[s] = value;
               shadow_mark[s]  = MARK_USED;
               shadow_count++;
               r.slot_index = s[LPHT_SLOT_OUT_W-1:0];
            end else begin
               r.status = STATUS_FULL;
            end
         end
         CMD_SEARCH: begin
            if (locate_key(key, s)) begin
               r.found_value = shadow_value[s];
               r.slot_index  = s[LPHT_SLOT_OUT_W-1:0];
            end else begin
               r.status = STATUS_NOT_FOUND;
            end
         end
         CMD_DELETE: begin
            if (locate_key(key, s)) begin
               shadow_mark[s] = MARK_DELETED;
               if (shadow_count > 0) shadow_count--;
               r.slot_index = s[LPHT_SLOT_OUT_W-1:0];
            end else begin
               r.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            for (int i = 0; i < TABLE_SLOTS; i++) shadow_mark[i] = MARK_EMPTY;
            shadow_count = 0;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      table_result_t want;
      table_result_t got;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) shadow_mark[i] = MARK_EMPTY;
         shadow_count = 0;
         awaited_results.delete();
         pending_results <= 0;
      end else begin
         // result side first: a result and a new request can share an edge
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tuser;
            got.found_value = rsp_tdata[LPHT_VALUE_W-1:0];
            got.slot_index  = rsp_tdata[LPHT_VALUE_W +: LPHT_SLOT_OUT_W];
            if (awaited_results.size() == 0) begin
               report_mismatch("unrequested result", got.status, 0);
            end else begin
               want = awaited_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.found_value != want.found_value)
                  report_mismatch("found_value", got.found_value, want.found_value);
               if (got.slot_index != want.slot_index)
                  report_mismatch("slot_index", got.slot_index, want.slot_index);
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(apply_request(lpht_cmd_type'(req_tuser),
                                                    req_tdata[LPHT_KEY_W-1:0],
                                                    req_tdata[LPHT_KEY_W +: LPHT_VALUE_W]));
         end
         pending_results <= awaited_results.size();
      end
   end

endmodule

// File: verif/testbench.sv
// Testbench top for the linear-probe hash table: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import lpht_pkg::*;

   localparam int SLOTS         = LPHT_DEFAULT_SLOTS;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int CALM_ITEMS    = 300;        // tail of the random part without idling
   localparam int HOLD_AT       = 200;        // result count that starts the long hold-off
   localparam int HOLD_CYCLES   = 600;
   localparam int POOL_DEPTH    = 64;
   // Worst case per item is a full probe lap plus hash, plus the longest gap on each side;
   // about 2600 items, the reset sweep and the hold-off, then taken four times over.
   localparam int CYCLE_LIMIT   = 12_000_000;
   localparam logic [LPHT_KEY_W-1:0] KEY_MAX = {LPHT_KEY_W{1'b1}};

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [LPHT_REQ_DATA_W-1:0] req_tdata  = '0;  // key[30:0], value[62:31], zero[63]
   logic [LPHT_CMD_W-1:0]      req_tuser  = '0;  // command[1:0]
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [LPHT_RSP_DATA_W-1:0] rsp_tdata;        // found_value[31:0], slot_index[41:32], zero
   logic [LPHT_STATUS_W-1:0]   rsp_tuser;        // status[1:0]

   logic idle_on = 1'b1;            // random idle bursts on both sides
   int   mismatch_count;
   int   pending_results;

   // receiver state
   int   rsp_pause_left = 0;
   int   rsp_count      = 0;
   bit   hold_done      = 1'b0;

   logic [LPHT_KEY_W-1:0] recent_keys [$];

   linear_probe_hash_table #(.TABLE_SLOTS(SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lpht_checker #(.TABLE_SLOTS(SLOTS)) result_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // synchronous reset, released once
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog: ends a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench failed");
      $finish;
   end

   // Result side. Random stall bursts while idling is on; once, after
   // HOLD_AT result transfers, a long hold-off so the block fills and drops req_tready
   // while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         rsp_pause_left <= 0;
         rsp_count      <= 0;
         hold_done      <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_count <= rsp_count + 1;
         if (!hold_done && rsp_count == HOLD_AT) begin
            hold_done      <= 1'b1;
            rsp_pause_left <= HOLD_CYCLES;
            rsp_tready     <= 1'b0;
         end else if (rsp_pause_left != 0) begin
            rsp_pause_left <= rsp_pause_left - 1;
            rsp_tready     <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_pause_left <= $urandom_range(0, 15);
            rsp_tready     <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One request transfer. tvalid stays high across back-to-back transfers; it only drops
   // for an idle burst, so it never gets two assignments in one time step.
   task automatic send_request(input lpht_cmd_type cmd, input logic [LPHT_KEY_W-1:0] key,
                               input logic [LPHT_VALUE_W-1:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, value, key};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
   endtask

   // A key whose home slot is s: key mod 7 == 6 makes the multiplier 1.
   function automatic logic [LPHT_KEY_W-1:0] key_at_slot(input int s);
      int k;
      k = s;
      for (int t = 0; t < LPHT_HASH_MULT; t++) begin
         if ((s + SLOTS * t) % LPHT_HASH_MULT == LPHT_HASH_MULT - 1) k = s + SLOTS * t;
      end
      return k[LPHT_KEY_W-1:0];
   endfunction

   // Keys crowded onto a few home slots at both ends of the table, so chains form and wrap.
   // Adding multiples of 7*SLOTS keeps both residues, hence the home slot.
   function automatic logic [LPHT_KEY_W-1:0] crowded_key();
      longint unsigned k;
      int s;
      s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : SLOTS - 16 + $urandom_range(0, 15);
      k = longint'(key_at_slot(s)) +
          longint'(LPHT_HASH_MULT * SLOTS) * $urandom_range(0, 299000);
      return k[LPHT_KEY_W-1:0];
   endfunction

   function automatic logic [LPHT_KEY_W-1:0] any_key();
      return $urandom() & KEY_MAX;
   endfunction

   function automatic logic [LPHT_KEY_W-1:0] known_key();
      if (recent_keys.size() == 0) return any_key();
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
   endfunction

   function automatic logic [LPHT_VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [LPHT_KEY_W-1:0] k;
      int r;

      @(posedge clock);
      while (reset) @(posedge clock);

      // ---- directed part ----
      send_request(CMD_SEARCH, '0, '0);                       // search on empty table
      send_request(CMD_DELETE, KEY_MAX, '1);                  // delete on empty table
      send_request(CMD_INSERT, '0, 32'h8000_0000);            // key 0 lands on slot 0
      send_request(CMD_INSERT, KEY_MAX, 32'h7FFF_FFFF);
      send_request(CMD_SEARCH, '0, '0);
      send_request(CMD_SEARCH, KEY_MAX, '0);
      send_request(CMD_INSERT, '0, 32'hFFFF_FFFF);            // duplicate: next free slot
      send_request(CMD_SEARCH, '0, '0);                       // finds the first copy
      send_request(CMD_DELETE, '0, '0);                       // tombstone on slot 0
      send_request(CMD_SEARCH, '0, '0);                       // walks past the tombstone
      send_request(CMD_INSERT, 31'd1024, 32'h0000_0000);      // same home, reuses tombstone
      send_request(CMD_SEARCH, 31'd1024, '0);
      send_request(CMD_DELETE, 31'd1024, '0);
      send_request(CMD_DELETE, '0, '0);
      send_request(CMD_SEARCH, '0, '0);                       // missing, past two tombstones
      k = key_at_slot(SLOTS - 1);
      send_request(CMD_INSERT, k, 32'h1234_5678);             // last slot
      send_request(CMD_INSERT, k, 32'h8765_4321);             // wraps to slot 0
      send_request(CMD_DELETE, k, '0);
      send_request(CMD_SEARCH, k, '0);                        // second copy after the wrap
      send_request(CMD_CLEAR, KEY_MAX, '1);
      send_request(CMD_SEARCH, KEY_MAX, '0);                  // gone after clear

      // ---- random part: mostly insert/search/delete on keys already in play ----
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
         r = $urandom_range(0, 99);
         if (r < 2) begin
            send_request(CMD_CLEAR, any_key(), pick_value());
            if ($urandom_range(0, 1) == 0) recent_keys.delete();
         end else if (r < 42) begin
            case ($urandom_range(0, 3))
               0, 1:    k = any_key();
               2:       k = known_key();
               default: k = crowded_key();
            endcase
            send_request(CMD_INSERT, k, pick_value());
            recent_keys.push_back(k);
            if (recent_keys.size() > POOL_DEPTH) void'(recent_keys.pop_front());
         end else if (r < 75) begin
            k = ($urandom_range(0, 4) == 0) ? any_key() : known_key();
            send_request(CMD_SEARCH, k, pick_value());
         end else begin
            k = ($urandom_range(0, 4) == 0) ? crowded_key() : known_key();
            send_request(CMD_DELETE, k, pick_value());
         end
      end

      // ---- full-table part: one key per home slot keeps every fill insert to one probe ----
      send_request(CMD_CLEAR, '0, '0);
      for (int s = 0; s < SLOTS; s++) send_request(CMD_INSERT, key_at_slot(s), $urandom());
      send_request(CMD_INSERT, KEY_MAX, 32'h5555_AAAA);       // table full
      send_request(CMD_SEARCH, KEY_MAX, '0);                  // missing, full lap
      send_request(CMD_SEARCH, key_at_slot(SLOTS - 1), '0);
      send_request(CMD_DELETE, key_at_slot(5), '0);
      send_request(CMD_DELETE, KEY_MAX, '0);                  // missing, lap over a tombstone
      send_request(CMD_INSERT, KEY_MAX, 32'hAAAA_5555);       // takes the tombstone
      send_request(CMD_SEARCH, KEY_MAX, '0);
      send_request(CMD_CLEAR, '0, '0);

      req_tvalid <= 1'b0;

      // drain: let the last transfer reach the checker, then wait for every result
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SLOTS + 16) @(posedge clock);

      if (mismatch_count == 0 && pending_results == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// File: linear_probe_hash_table.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_hash.sv
rtl/linear_probe_hash_table.sv
verif/lpht_checker.sv
verif/testbench.sv
